// ===== rtl/hashed_page_table_defines.svh =====
// ----------------------------------------------------------------------------
// hashed page table assertion macros
// concurrent checks, compiled out when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef HASHED_PAGE_TABLE_DEFINES_SVH
`define HASHED_PAGE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define HPT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hashed_page_table: assertion failed");
`define HPT_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("hashed_page_table: forbidden condition");
`else
`define HPT_ASSERT(label, clk, rst_n, prop)
`define HPT_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ===== rtl/hpt_pkg.sv =====
// ----------------------------------------------------------------------------
// hpt_pkg
// shared types, codes and defaults of the hashed page table
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

    localparam int BUCKETS_DEF    = 1024;
    localparam int ENTRIES_DEF    = 1024;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int PAGE_W = 52;
    localparam int VA_W   = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [PAGE_W-1:0] page_number;
        logic [VA_W-1:0]   virtual_address;
        logic [11:0]       frame;
        logic              cache_flag;
        logic              referenced_flag;
        logic              modified_flag;
        logic [2:0]        protection;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] found_frame;
        logic        found_cache;
        logic        found_referenced;
        logic        found_modified;
        logic [2:0]  found_protection;
    } rsp_word_t;

    typedef struct packed {
        logic [11:0] frame;
        logic        cache;
        logic        referenced;
        logic        modified;
        logic [2:0]  protection;
    } attrs_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [PAGE_W-1:0] page;
        attrs_t            attrs;
    } cmd_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        attrs_t            attrs;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/hpt_front.sv =====
// ----------------------------------------------------------------------------
// hpt_front
// accepts request words, forms the page and its bucket, queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_front
    import hpt_pkg::*;
#(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    localparam int BW        = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          clearing,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire req_word_t     req,
    output logic               q_valid,
    output cmd_t               q_cmd,
    output logic [BW-1:0]      q_bucket,
    input  wire logic          q_pop
);

    localparam int  DIG    = 4;
    localparam int  STEPS  = (PAGE_W + DIG - 1) / DIG;
    localparam int  SW     = STEPS * DIG;
    localparam int  CW     = $clog2(STEPS + 1);
    localparam bit  POW2   = ((1 << BW) == BUCKETS);
    localparam logic [CW-1:0] CNT_LOAD = POW2 ? CW'(0) : CW'(STEPS);
    localparam logic [BW:0]   BMOD     = (BW+1)'(BUCKETS);

    logic                wk_valid_reg, wk_valid_next;
    cmd_t                wk_cmd_reg, wk_cmd_next;
    logic [SW-1:0]       wk_shift_reg, wk_shift_next;
    logic [BW-1:0]       rem_reg, rem_next;
    logic [CW-1:0]       cnt_reg, cnt_next;

    cmd_t                q_cmd_reg [2];
    logic [BW-1:0]       q_bkt_reg [2];
    logic                q_wp_reg, q_rp_reg;
    logic [1:0]          q_cnt_reg;

    logic                push;
    logic                accept;
    logic [VA_W-1:0]     va_shifted;
    cmd_t                new_cmd;
    logic [BW-1:0]       rem_step;
    logic [BW:0]         trial;
    logic [BW-1:0]       push_bucket;

    assign push      = wk_valid_reg && (cnt_reg == '0) && (q_cnt_reg != 2'd2);
    assign req_ready = !clearing && (!wk_valid_reg || push);
    assign accept    = req_valid && req_ready;

    assign va_shifted  = req.virtual_address >> PAGE_SHIFT;
    assign push_bucket = POW2 ? wk_cmd_reg.page[BW-1:0] : rem_reg;

    always_comb
    begin
        new_cmd.op               = req.op;
        new_cmd.page             = (req.op == OP_LOOKUP) ? va_shifted[PAGE_W-1:0]
                                                         : req.page_number;
        new_cmd.attrs.frame      = req.frame;
        new_cmd.attrs.cache      = req.cache_flag;
        new_cmd.attrs.referenced = req.referenced_flag;
        new_cmd.attrs.modified   = req.modified_flag;
        new_cmd.attrs.protection = req.protection;
    end

    // residue of the page, one hex digit per cycle
    always_comb
    begin
        rem_step = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIG; i++)
        begin
            trial = {rem_step, wk_shift_reg[SW-1-i]};
            if (trial >= BMOD)
            begin
                trial = trial - BMOD;
            end
            rem_step = trial[BW-1:0];
        end
    end

    always_comb
    begin
        wk_valid_next = wk_valid_reg;
        wk_cmd_next   = wk_cmd_reg;
        wk_shift_next = wk_shift_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        if (push)
        begin
            wk_valid_next = 1'b0;
        end
        if (wk_valid_reg && (cnt_reg != '0))
        begin
            rem_next      = rem_step;
            wk_shift_next = wk_shift_reg << DIG;
            cnt_next      = cnt_reg - CW'(1);
        end
        if (accept)
        begin
            wk_valid_next = 1'b1;
            wk_cmd_next   = new_cmd;
            wk_shift_next = SW'(new_cmd.page);
            rem_next      = '0;
            cnt_next      = CNT_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wk_valid_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            wk_valid_reg <= wk_valid_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wk_cmd_reg   <= wk_cmd_next;
        wk_shift_reg <= wk_shift_next;
        rem_reg      <= rem_next;
    end

    // two-word command queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= 1'b0;
            q_rp_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                q_wp_reg <= !q_wp_reg;
            end
            if (q_pop)
            begin
                q_rp_reg <= !q_rp_reg;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd_reg[q_wp_reg] <= wk_cmd_reg;
            q_bkt_reg[q_wp_reg] <= push_bucket;
        end
    end

    assign q_valid  = (q_cnt_reg != 2'd0);
    assign q_cmd    = q_cmd_reg[q_rp_reg];
    assign q_bucket = q_bkt_reg[q_rp_reg];

endmodule

`default_nettype wire

// ===== rtl/hpt_back.sv =====
// ----------------------------------------------------------------------------
// hpt_back
// walks bucket chains in the table memories and produces response words
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_back
    import hpt_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int XW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int IW     = $clog2(ENTRIES + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    output logic               clearing,
    input  wire logic          q_valid,
    input  wire cmd_t          q_cmd,
    input  wire logic [BW-1:0] q_bucket,
    output logic               q_pop,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output rsp_word_t          rsp
);

    localparam logic [IW-1:0] NIL      = IW'(ENTRIES);
    localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HEAD  = 5'b00100,
        S_WALK  = 5'b01000,
        S_CMP   = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [BW-1:0]   bucket_reg, bucket_next;
    logic [IW-1:0]   cur_reg, cur_next;
    logic [IW-1:0]   prev_reg, prev_next;
    logic [XW-1:0]   slot_reg, slot_next;
    logic [IW-1:0]   free_reg, free_next;
    logic [IW-1:0]   min_reg, min_next;
    logic [BW-1:0]   clr_reg, clr_next;
    logic            out_valid_reg, out_valid_next;
    rsp_word_t       out_word_reg, out_word_next;

    logic [IW-1:0]   bucket_mem [BUCKETS];
    entry_t          entry_mem [ENTRIES];
    logic [IW-1:0]   next_mem [ENTRIES];
    logic [XW-1:0]   stack_mem [ENTRIES];

    logic [IW-1:0]   bk_rdata_reg;
    entry_t          en_rdata_reg;
    logic [IW-1:0]   nx_rdata_reg;
    logic [XW-1:0]   st_rdata_reg;

    logic            bk_we;
    logic [BW-1:0]   bk_waddr;
    logic [IW-1:0]   bk_wdata;
    logic            nx_we;
    logic [XW-1:0]   nx_waddr;
    logic [IW-1:0]   nx_wdata;
    logic            en_we;
    logic            st_we;
    logic [XW-1:0]   rd_addr;
    logic [IW-1:0]   pos;
    logic            pos_fresh;
    logic [XW-1:0]   slot_pick;
    logic            out_free;
    logic            emit;
    rsp_word_t       emit_word;

    assign pos       = free_reg - IW'(1);
    assign pos_fresh = (pos < min_reg);
    assign slot_pick = pos_fresh ? pos[XW-1:0] : st_rdata_reg;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign rd_addr   = (state_reg == S_HEAD) ? bk_rdata_reg[XW-1:0] : nx_rdata_reg[XW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        bucket_next    = bucket_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        slot_next      = slot_reg;
        free_next      = free_reg;
        min_next       = min_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_word_next  = out_word_reg;
        bk_we          = 1'b0;
        bk_waddr       = bucket_reg;
        bk_wdata       = NIL;
        nx_we          = 1'b0;
        nx_waddr       = slot_pick;
        nx_wdata       = NIL;
        en_we          = 1'b0;
        st_we          = 1'b0;
        q_pop          = 1'b0;
        emit           = 1'b0;
        emit_word      = '0;

        case (state_reg)
            S_CLEAR:
            begin
                bk_we    = 1'b1;
                bk_waddr = clr_reg;
                clr_next = clr_reg + BW'(1);
                if (clr_reg == LAST_BKT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop       = 1'b1;
                    cmd_next    = q_cmd;
                    bucket_next = q_bucket;
                    case (q_cmd.op)
                        OP_INSERT:
                        begin
                            if (free_reg == '0)
                            begin
                                emit             = 1'b1;
                                emit_word.status = STAT_FULL;
                            end
                            else
                            begin
                                state_next = S_HEAD;
                            end
                        end
                        OP_REMOVE, OP_LOOKUP:
                        begin
                            state_next = S_HEAD;
                        end
                        default:
                        begin
                            emit             = 1'b1;
                            emit_word.status = STAT_MISS;
                        end
                    endcase
                end
            end
            S_HEAD:
            begin
                if (cmd_reg.op == OP_INSERT)
                begin
                    en_we     = 1'b1;
                    nx_we     = 1'b1;
                    free_next = pos;
                    slot_next = slot_pick;
                    if (pos_fresh)
                    begin
                        min_next = pos;
                    end
                    if (bk_rdata_reg >= NIL)
                    begin
                        bk_we            = 1'b1;
                        bk_wdata         = IW'(slot_pick);
                        emit             = 1'b1;
                        emit_word.status = STAT_OK;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = bk_rdata_reg;
                        state_next = S_WALK;
                    end
                end
                else if (bk_rdata_reg >= NIL)
                begin
                    emit             = 1'b1;
                    emit_word.status = STAT_MISS;
                    state_next       = S_IDLE;
                end
                else
                begin
                    cur_next   = bk_rdata_reg;
                    prev_next  = NIL;
                    state_next = S_CMP;
                end
            end
            S_WALK:
            begin
                if (nx_rdata_reg >= NIL)
                begin
                    nx_we            = 1'b1;
                    nx_waddr         = cur_reg[XW-1:0];
                    nx_wdata         = IW'(slot_reg);
                    emit             = 1'b1;
                    emit_word.status = STAT_OK;
                    state_next       = S_IDLE;
                end
                else
                begin
                    cur_next = nx_rdata_reg;
                end
            end
            S_CMP:
            begin
                if (en_rdata_reg.page == cmd_reg.page)
                begin
                    emit             = 1'b1;
                    emit_word.status = STAT_OK;
                    state_next       = S_IDLE;
                    if (cmd_reg.op == OP_LOOKUP)
                    begin
                        emit_word.found_frame      = en_rdata_reg.attrs.frame;
                        emit_word.found_cache      = en_rdata_reg.attrs.cache;
                        emit_word.found_referenced = en_rdata_reg.attrs.referenced;
                        emit_word.found_modified   = en_rdata_reg.attrs.modified;
                        emit_word.found_protection = en_rdata_reg.attrs.protection;
                    end
                    else
                    begin
                        if (prev_reg >= NIL)
                        begin
                            bk_we    = 1'b1;
                            bk_wdata = nx_rdata_reg;
                        end
                        else
                        begin
                            nx_we    = 1'b1;
                            nx_waddr = prev_reg[XW-1:0];
                            nx_wdata = nx_rdata_reg;
                        end
                        if (free_reg < NIL)
                        begin
                            st_we     = 1'b1;
                            free_next = free_reg + IW'(1);
                        end
                    end
                end
                else if (nx_rdata_reg >= NIL)
                begin
                    emit             = 1'b1;
                    emit_word.status = STAT_MISS;
                    state_next       = S_IDLE;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = nx_rdata_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = emit_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_reg      <= NIL;
            min_reg       <= NIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_reg      <= free_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        bucket_reg   <= bucket_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        slot_reg     <= slot_next;
        out_word_reg <= out_word_next;
    end

    // bucket heads
    always_ff @(posedge clk)
    begin
        if (bk_we)
        begin
            bucket_mem[bk_waddr] <= bk_wdata;
        end
        bk_rdata_reg <= bucket_mem[q_bucket];
    end

    // entry page and attributes
    always_ff @(posedge clk)
    begin
        if (en_we)
        begin
            entry_mem[slot_pick] <= {cmd_reg.page, cmd_reg.attrs};
        end
        en_rdata_reg <= entry_mem[rd_addr];
    end

    // chain links
    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        nx_rdata_reg <= next_mem[rd_addr];
    end

    // returned entries; slots below the low-water mark are not read, their own index is used instead
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stack_mem[free_reg[XW-1:0]] <= cur_reg[XW-1:0];
        end
        st_rdata_reg <= stack_mem[pos[XW-1:0]];
    end

    assign clearing  = (state_reg == S_CLEAR);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_word_reg;

endmodule

`default_nettype wire

// ===== rtl/hashed_page_table.sv =====
// ----------------------------------------------------------------------------
// hashed_page_table
// hashed page table with chained buckets over a fixed entry pool
//
//   channel | dir | handshake            | word
//   req     | in  | req_valid/req_ready  | req_word_t: op, page, address, attrs
//   rsp     | out | rsp_valid/rsp_ready  | rsp_word_t: status, found attrs
//
// front: when BUCKETS is a power of two the bucket is the page's low bits, else
// the residue is formed one hex digit per cycle; a new word is taken only as the
// last one moves to the queue. back: a bucket head read, then one read of the
// link memory per chain entry visited. after reset the bucket heads are swept
// and req_ready stays low. a stalled response holds the back end; the front
// keeps taking words until its two-word queue is full.
`default_nettype none

module hashed_page_table
    import hpt_pkg::*;
#(
    parameter int BUCKETS    = BUCKETS_DEF,
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire req_word_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_word_t      rsp
);

`include "hashed_page_table_defines.svh"

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    logic            clearing;
    logic            q_valid;
    cmd_t            q_cmd;
    logic [BW-1:0]   q_bucket;
    logic            q_pop;

    hpt_front #(
        .BUCKETS    (BUCKETS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_bucket  (q_bucket),
        .q_pop     (q_pop)
    );

    hpt_back #(
        .BUCKETS (BUCKETS),
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_bucket  (q_bucket),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `HPT_ASSERT_NEVER(a_no_accept_in_clear, clk, rst_n, clearing && req_ready)
    `HPT_ASSERT_NEVER(a_no_rsp_in_clear, clk, rst_n, clearing && rsp_valid)
    `HPT_ASSERT_NEVER(a_no_pop_in_clear, clk, rst_n, clearing && q_pop)
    `HPT_ASSERT(a_status_code, clk, rst_n, rsp_valid |-> (rsp.status <= STAT_FULL))
    `HPT_ASSERT_NEVER(a_miss_zero, clk, rst_n, rsp_valid && rsp.status != STAT_OK && |rsp.found_frame)

endmodule

`default_nettype wire

// ===== tb/hashed_page_table_tb.sv =====
// ----------------------------------------------------------------------------
// hashed_page_table_tb
// drives insert, remove and lookup words through the request channel and
// checks every response against a behavioral page table kept in the bench;
// covers chain heads and tails, duplicates, wide addresses and the unused
// op code under several idle and stall patterns
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_page_table_tb;
    import hpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT  = BUCKETS_DEF;
    localparam int NENT  = ENTRIES_DEF;
    localparam int SHIFT = PAGE_SHIFT_DEF;
    localparam int REQ_W = $bits(req_word_t);
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_word_t rsp;

    hashed_page_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // behavioral table: each bucket is an ordered list of entries
    entry_t    chain_q[NBKT][$];
    int        used_count;
    rsp_word_t pending_rsp_q[$];
    int        errors;
    int        sent_count;
    int        rsp_count;
    int        hit_count;
    int        full_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_cycles;
    logic [PAGE_W-1:0] used_pages[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("hashed_page_table_tb failed");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch at response %0d: %s got %0h expected %0h", rsp_count, what, got, want);
    endtask

    function automatic rsp_word_t table_step(input req_word_t w);
        rsp_word_t r;
        logic [PAGE_W-1:0] pg;
        int b;
        r = '0;
        case (w.op)
            OP_INSERT:
            begin
                if (used_count >= NENT)
                    r.status = STAT_FULL;
                else
                begin
                    chain_q[w.page_number % NBKT].push_back({w.page_number,
                        w.frame, w.cache_flag, w.referenced_flag, w.modified_flag,
                        w.protection});
                    used_count++;
                    r.status = STAT_OK;
                end
            end
            OP_REMOVE:
            begin
                b = int'(w.page_number % NBKT);
                r.status = STAT_MISS;
                foreach (chain_q[b][i])
                    if (chain_q[b][i].page == w.page_number)
                    begin
                        chain_q[b].delete(i);
                        used_count--;
                        r.status = STAT_OK;
                        break;
                    end
            end
            OP_LOOKUP:
            begin
                pg = PAGE_W'(w.virtual_address >> SHIFT);
                b = int'(pg % NBKT);
                r.status = STAT_MISS;
                foreach (chain_q[b][i])
                    if (chain_q[b][i].page == pg)
                    begin
                        r.status           = STAT_OK;
                        r.found_frame      = chain_q[b][i].attrs.frame;
                        r.found_cache      = chain_q[b][i].attrs.cache;
                        r.found_referenced = chain_q[b][i].attrs.referenced;
                        r.found_modified   = chain_q[b][i].attrs.modified;
                        r.found_protection = chain_q[b][i].attrs.protection;
                        break;
                    end
            end
            default: r.status = STAT_MISS;
        endcase
        return r;
    endfunction

    // response side: stall at random, or hold off for a counted stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        rsp_word_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                report("unexpected word", rsp, 0);
            end
            else
            begin
                e = pending_rsp_q.pop_front();
                if (rsp.status !== e.status) report("status", rsp.status, e.status);
                if (rsp.found_frame !== e.found_frame)
                    report("frame", rsp.found_frame, e.found_frame);
                if (rsp.found_cache !== e.found_cache)
                    report("cache", rsp.found_cache, e.found_cache);
                if (rsp.found_referenced !== e.found_referenced)
                    report("referenced", rsp.found_referenced, e.found_referenced);
                if (rsp.found_modified !== e.found_modified)
                    report("modified", rsp.found_modified, e.found_modified);
                if (rsp.found_protection !== e.found_protection)
                    report("protection", rsp.found_protection, e.found_protection);
                if (e.status == STAT_OK && rsp.found_frame !== 0) hit_count++;
                if (e.status == STAT_FULL) full_count++;
            end
            rsp_count++;
        end
    end

    // send one word; valid stays high between back-to-back words
    task automatic send_word(input req_word_t w, input rsp_word_t typed, input bit has_typed);
        rsp_word_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        p = table_step(w);
        if (has_typed && p !== typed)
            report("table row", p, typed);
        pending_rsp_q.push_back(p);
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
        sent_count++;
    endtask

    function automatic req_word_t make_word(input logic [1:0] op,
        input logic [PAGE_W-1:0] pg, input logic [VA_W-1:0] va,
        input logic [11:0] fr, input logic [2:0] fl, input logic [2:0] pr);
        req_word_t w;
        w.op = op; w.page_number = pg; w.virtual_address = va; w.frame = fr;
        {w.cache_flag, w.referenced_flag, w.modified_flag} = fl;
        w.protection = pr;
        return w;
    endfunction

    function automatic logic [PAGE_W-1:0] rand_page();
        return PAGE_W'({$urandom(), $urandom()});
    endfunction

    function automatic req_word_t rand_word(input int fill_bias);
        req_word_t w;
        logic [PAGE_W-1:0] pg;
        int k;
        w = REQ_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        k = $urandom_range(99);
        // mostly a small page set over few buckets so chains grow and repeat
        if (used_pages.size() > 0 && $urandom_range(3) != 0)
            pg = used_pages[$urandom_range(used_pages.size() - 1)];
        else
        begin
            pg = ($urandom_range(1) != 0) ? rand_page()
                 : PAGE_W'({rand_page() >> 20, 10'($urandom_range(7))});
            used_pages.push_back(pg);
        end
        w.page_number = pg;
        if (k < fill_bias) w.op = OP_INSERT;
        else if (k < fill_bias + 20) w.op = OP_REMOVE;
        else if (k < 98) w.op = OP_LOOKUP;
        else w.op = OP_UNUSED;
        if (w.op == OP_LOOKUP && $urandom_range(4) != 0)
            w.virtual_address = VA_W'({pg, w.virtual_address[SHIFT-1:0]});
        return w;
    endfunction

    typedef struct {
        req_word_t w;
        rsp_word_t r;
        bit        typed;
    } row_t;

    row_t rows[$];

    task automatic drain();
        int guard;
        guard = 0;
        req_valid <= 1'b0;
        while (pending_rsp_q.size() > 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (50) @(posedge clk);
    endtask

    task automatic run_random(input int n, input int fill_bias);
        repeat (n) send_word(rand_word(fill_bias), '0, 1'b0);
    endtask

    initial
    begin
        rsp_word_t ok, miss;
        logic [PAGE_W-1:0] maxp;
        errors = 0; sent_count = 0; rsp_count = 0; hit_count = 0; full_count = 0;
        used_count = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        ok = '0; ok.status = STAT_OK;
        miss = '0; miss.status = STAT_MISS;
        maxp = '1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        rows = '{
            '{make_word(OP_LOOKUP, 0, 0, 0, 0, 0), miss, 1},
            '{make_word(OP_REMOVE, 0, '1, '1, 3'b111, 7), miss, 1},
            '{make_word(OP_UNUSED, maxp, '1, '1, 3'b111, 7), miss, 1},
            '{make_word(OP_INSERT, 0, 0, 0, 0, 0), ok, 1},
            '{make_word(OP_INSERT, maxp, 0, 12'hfff, 3'b111, 7), ok, 1},
            '{make_word(OP_INSERT, PAGE_W'(NBKT), 0, 12'h5a5, 3'b101, 5), ok, 1},
            '{make_word(OP_INSERT, PAGE_W'(2 * NBKT), 0, 12'ha5a, 3'b010, 2), ok, 1},
            '{make_word(OP_INSERT, PAGE_W'(NBKT), 0, 12'h111, 3'b001, 1), ok, 1},
            '{make_word(OP_LOOKUP, 0, '1, 0, 0, 0), '0, 0},
            '{make_word(OP_LOOKUP, 0, {12'h000, maxp}, 0, 0, 0), '0, 0},
            '{make_word(OP_LOOKUP, 0, 64'(NBKT) << SHIFT, 0, 0, 0), '0, 0},
            '{make_word(OP_LOOKUP, 0, (64'(2 * NBKT) << SHIFT) | 64'hfff, 0, 0, 0), '0, 0},
            '{make_word(OP_LOOKUP, 0, 0, 0, 0, 0), '0, 0},
            '{make_word(OP_REMOVE, 0, 0, 0, 0, 0), ok, 1},
            '{make_word(OP_LOOKUP, 0, 0, 0, 0, 0), miss, 1},
            '{make_word(OP_REMOVE, PAGE_W'(NBKT), 0, 0, 0, 0), ok, 1},
            '{make_word(OP_LOOKUP, 0, 64'(NBKT) << SHIFT, 0, 0, 0), '0, 0},
            '{make_word(OP_REMOVE, PAGE_W'(2 * NBKT), 0, 0, 0, 0), ok, 1},
            '{make_word(OP_REMOVE, PAGE_W'(3 * NBKT), 0, 0, 0, 0), miss, 1},
            '{make_word(OP_REMOVE, maxp, 0, 0, 0, 0), ok, 1},
            '{make_word(OP_REMOVE, PAGE_W'(NBKT), 0, 0, 0, 0), ok, 1}
        };
        foreach (rows[i])
            send_word(rows[i].w, rows[i].r, rows[i].typed);
        drain();

        // phases: none, sender idle, receiver stall, both
        run_random(120, 40);
        send_idle_pct = 72;
        run_random(100, 40);
        send_idle_pct = 0; recv_stall_pct = 72;
        run_random(100, 40);
        send_idle_pct = 28; recv_stall_pct = 28;
        run_random(100, 40);

        // long receiver hold while the sender keeps offering
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_cycles = 300;
        run_random(20, 40);
        drain();

        recv_stall_pct = 10;
        run_random(160, 50);
        drain();

        $display("ran %0d words: %0d hits with data, %0d pool-full responses",
            sent_count, hit_count, full_count);
        $display("covered chain heads, duplicates, wide addresses and long stalls");
        if (errors == 0 && pending_rsp_q.size() == 0)
            $display("hashed_page_table_tb passed");
        else
            $display("hashed_page_table_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
